// ----- rtl/core/splb_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted price level book package
// Shared payload types, commands and constants of the price level table.
// ----------------------------------------------------------------------------
package splb_pkg;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_NOP    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [5:0] MAX_READ = 6'd32;
    localparam logic signed [47:0] PAD_HIGH = 48'sd9999999999;
    localparam logic signed [47:0] PAD_LOW  = -48'sd9999999999;
    localparam logic [39:0] SIZE_MAX = '1;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [47:0] price;
        logic [31:0]        quantity;
        logic [5:0]         read_count;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [47:0] level_price;
        logic [39:0]        level_size;
        logic               last;
    } t_out;

    typedef struct packed {
        logic load;
        logic compare;
        logic select;
        logic update;
        logic read_emit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       read_zero;
        logic       read_last;
        logic       out_free;
    } t_sts;

endpackage

// ----- rtl/core/splb_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sorted price level book controller
// Sequences load, compare, select, update and read beats of one item.
// ----------------------------------------------------------------------------
module splb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  splb_pkg::t_sts i_sts,
    output splb_pkg::t_cmd o_cmd
);
    import splb_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                if (i_sts.func == FUNC_READ) begin
                    n_state = i_sts.read_zero ? S_IDLE : S_READ;
                end else begin
                    n_state = S_SEL;
                end
            end
            S_SEL: begin
                o_cmd.select = 1'b1;
                n_state      = S_UPD;
            end
            S_UPD: begin
                if (i_sts.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_READ: begin
                if (i_sts.out_free) begin
                    o_cmd.read_emit = 1'b1;
                    if (i_sts.read_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_update_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.update || o_cmd.read_emit) |-> i_sts.out_free)
        else $error("result issued while output register busy");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_CMP))
        else $error("load not followed by compare");
    a_read_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !i_sts.read_zero)
        else $error("read sequence entered with zero count");

endmodule

// ----- rtl/core/splb_dp.sv -----
// ----------------------------------------------------------------------------
// Sorted price level book datapath
// Register table with parallel compare, shift insert and delete, and output.
// ----------------------------------------------------------------------------
module splb_dp #(
    parameter int DEPTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  splb_pkg::t_in  i_in_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_data,
    input  splb_pkg::t_cmd i_cmd,
    output splb_pkg::t_sts o_sts,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output splb_pkg::t_out o_out_data
);
    import splb_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [47:0] r_tp [DEPTH];
    logic [39:0]        r_ts [DEPTH];
    logic signed [47:0] n_tp [DEPTH];
    logic [39:0]        n_ts [DEPTH];
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      n_cnt;
    logic               r_asc;
    logic [1:0]         r_func;
    logic signed [47:0] r_price;
    logic [31:0]        r_qty;
    logic [5:0]         r_n;
    logic [5:0]         r_k;
    logic [DEPTH-1:0]   r_better;
    logic [DEPTH-1:0]   r_hit;
    logic               r_hit_any;
    logic [39:0]        r_hit_size;
    logic               r_out_valid;
    t_out               r_out;
    t_out               n_out;
    logic [DEPTH-1:0]   w_better;
    logic [DEPTH-1:0]   w_hit;
    logic [39:0]        w_sel;
    logic [40:0]        w_sum;
    logic [39:0]        w_add;
    logic [39:0]        w_rem;
    logic               w_k_live;

    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;
    assign o_sts.func      = r_func;
    assign o_sts.read_zero = (r_n == 6'd0);
    assign o_sts.read_last = ((r_k + 6'd1) == r_n);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // The search position is the first level that is not strictly better, so
    // the better mask is kept as a prefix even if the sort order was changed.
    always_comb begin
        logic run;
        run = 1'b1;
        for (int i = 0; i < DEPTH; i++) begin
            w_hit[i]    = run && (7'(i) < 7'(r_cnt)) && (r_tp[i] == r_price);
            run         = run && (7'(i) < 7'(r_cnt)) &&
                          (r_asc ? (r_tp[i] < r_price) : (r_tp[i] > r_price));
            w_better[i] = run;
        end
    end

    always_comb begin
        w_sel = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_sel = w_sel | (r_ts[i] & {40{r_hit[i]}});
        end
    end

    assign w_sum    = {1'b0, r_hit_size} + {9'd0, r_qty};
    assign w_add    = w_sum[40] ? SIZE_MAX : w_sum[39:0];
    assign w_rem    = r_hit_size - {8'd0, r_qty};
    assign w_k_live = (7'(r_k) < 7'(r_cnt));

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_tp[i] = r_tp[i];
            n_ts[i] = r_ts[i];
        end
        n_cnt = r_cnt;
        n_out = '0;
        n_out.last = 1'b1;
        n_out.level_price = r_price;
        if (i_cmd.update) begin
            case (r_func)
                FUNC_ADD: begin
                    if (r_hit_any) begin
                        for (int i = 0; i < DEPTH; i++) begin
                            if (r_hit[i]) begin
                                n_ts[i] = w_add;
                            end
                        end
                        n_out.level_size = w_add;
                    end else if (r_cnt >= CW'(DEPTH)) begin
                        n_out.status = ST_FULL;
                    end else begin
                        for (int i = 0; i < DEPTH; i++) begin
                            if (!r_better[i]) begin
                                if (i == 0 || r_better[(i > 0) ? i - 1 : 0]) begin
                                    n_tp[i] = r_price;
                                    n_ts[i] = {8'd0, r_qty};
                                end else begin
                                    n_tp[i] = r_tp[(i > 0) ? i - 1 : 0];
                                    n_ts[i] = r_ts[(i > 0) ? i - 1 : 0];
                                end
                            end
                        end
                        n_cnt = r_cnt + CW'(1);
                        n_out.level_size = {8'd0, r_qty};
                    end
                end
                FUNC_REMOVE: begin
                    if (!r_hit_any || (r_hit_size < {8'd0, r_qty})) begin
                        n_out.status = ST_REJECTED;
                    end else if (w_rem == 40'd0) begin
                        for (int i = 0; i + 1 < DEPTH; i++) begin
                            if (!r_better[i]) begin
                                n_tp[i] = r_tp[i + 1];
                                n_ts[i] = r_ts[i + 1];
                            end
                        end
                        n_cnt = r_cnt - CW'(1);
                    end else begin
                        for (int i = 0; i < DEPTH; i++) begin
                            if (r_hit[i]) begin
                                n_ts[i] = w_rem;
                            end
                        end
                        n_out.level_size = w_rem;
                    end
                end
                default: begin
                    n_out.level_price = '0;
                end
            endcase
        end else begin
            n_out.last = o_sts.read_last;
            if (w_k_live) begin
                n_out.level_price = r_tp[r_k[IW-1:0]];
                n_out.level_size  = r_ts[r_k[IW-1:0]];
            end else begin
                n_out.level_price = r_asc ? PAD_HIGH : PAD_LOW;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_asc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_asc <= i_cfg_data;
            end
            r_cnt <= n_cnt;
            if (i_cmd.update || i_cmd.read_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_tp[i] <= n_tp[i];
            r_ts[i] <= n_ts[i];
        end
        if (i_cmd.load) begin
            r_func  <= i_in_data.func;
            r_price <= i_in_data.price;
            r_qty   <= i_in_data.quantity;
            r_n     <= (i_in_data.read_count > MAX_READ) ? MAX_READ : i_in_data.read_count;
            r_k     <= '0;
        end
        if (i_cmd.read_emit) begin
            r_k <= r_k + 6'd1;
        end
        if (i_cmd.compare) begin
            r_better <= w_better;
            r_hit    <= w_hit;
        end
        if (i_cmd.select) begin
            r_hit_any  <= |r_hit;
            r_hit_size <= w_sel;
        end
        if (i_cmd.update || i_cmd.read_emit) begin
            r_out <= n_out;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        7'(r_cnt) <= 7'(DEPTH))
        else $error("level count above table depth");
    a_hit_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.select |-> $onehot0(r_hit))
        else $error("price matched more than one level");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_cmd.update) |-> (r_cnt == $past(r_cnt)))
        else $error("level count changed outside an update");

endmodule

// ----- rtl/core/sorted_price_level_book_top.sv -----
// ----------------------------------------------------------------------------
// Sorted price level book
// One side of an order book as a sorted table of price levels.
// ----------------------------------------------------------------------------
// An add or remove passes from acceptance to its result beat through load,
// parallel compare of all levels, selection of the matched level and update
// with shift insert or delete. A read of n levels (n at most 32) passes
// load and compare, then gives one beat per level; stalls hold the beats.
// The next item is accepted in the cycle after the last result is issued.
module sorted_price_level_book_top #(
    parameter int DEPTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  splb_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output splb_pkg::t_out   o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_data
);
    import splb_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    splb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    splb_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- dv/sorted_price_level_book_checker.sv -----
// ----------------------------------------------------------------------------
// Sorted price level book checker
// Watches the input, output and configuration channels, keeps its own copy
// of the price level table, and compares every result beat field by field
// with the oldest predicted beat.
// ----------------------------------------------------------------------------
module sorted_price_level_book_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_stall,
    input  splb_pkg::t_in   i_in_data,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  splb_pkg::t_out  i_out_data,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_ready,
    input  logic            i_cfg_data,
    output int              o_errors,
    output int              o_pending,
    output int              o_in_beats,
    output int              o_out_beats
);
    import splb_pkg::*;

    localparam int BOOK_DEPTH = 32;

    logic signed [47:0] book_prices [BOOK_DEPTH];
    logic [39:0]        book_sizes  [BOOK_DEPTH];
    int                 book_count;
    logic               ask_order;
    t_out               expected_levels_q [$];

    function automatic t_out make_level(logic [1:0] st, logic signed [47:0] p,
                                        logic [39:0] sz, logic lst);
        t_out r;
        r.status      = st;
        r.level_price = p;
        r.level_size  = sz;
        r.last        = lst;
        return r;
    endfunction

    task automatic queue_level(t_out lvl);
        expected_levels_q = {expected_levels_q, lvl};
    endtask

    task automatic book_update(t_in it);
        int          pos;
        int          n;
        bit          hit;
        logic [40:0] sum;
        pos = 0;
        while (pos < book_count &&
               (ask_order ? (book_prices[pos] < it.price) : (book_prices[pos] > it.price)))
            pos++;
        hit = (pos < book_count) && (book_prices[pos] == it.price);
        case (it.func)
            FUNC_ADD: begin
                if (hit) begin
                    sum = {1'b0, book_sizes[pos]} + it.quantity;
                    book_sizes[pos] = sum[40] ? SIZE_MAX : sum[39:0];
                    queue_level(make_level(ST_OK, it.price, book_sizes[pos], 1'b1));
                end else if (book_count >= BOOK_DEPTH) begin
                    queue_level(make_level(ST_FULL, it.price, '0, 1'b1));
                end else begin
                    for (int i = book_count; i > pos; i--) begin
                        book_prices[i] = book_prices[i-1];
                        book_sizes[i]  = book_sizes[i-1];
                    end
                    book_prices[pos] = it.price;
                    book_sizes[pos]  = {8'd0, it.quantity};
                    book_count++;
                    queue_level(make_level(ST_OK, it.price, {8'd0, it.quantity}, 1'b1));
                end
            end
            FUNC_REMOVE: begin
                if (!hit || book_sizes[pos] < {8'd0, it.quantity}) begin
                    queue_level(make_level(ST_REJECTED, it.price, '0, 1'b1));
                end else begin
                    book_sizes[pos] = book_sizes[pos] - it.quantity;
                    queue_level(make_level(ST_OK, it.price, book_sizes[pos], 1'b1));
                    if (book_sizes[pos] == '0) begin
                        for (int i = pos; i + 1 < book_count; i++) begin
                            book_prices[i] = book_prices[i+1];
                            book_sizes[i]  = book_sizes[i+1];
                        end
                        book_count--;
                    end
                end
            end
            FUNC_READ: begin
                n = (it.read_count > MAX_READ) ? MAX_READ : it.read_count;
                for (int i = 0; i < n; i++) begin
                    if (i < book_count)
                        queue_level(make_level(ST_OK, book_prices[i],
                                               book_sizes[i], i + 1 == n));
                    else
                        queue_level(make_level(ST_OK,
                            ask_order ? PAD_HIGH : PAD_LOW, '0, i + 1 == n));
                end
            end
            default: begin
                queue_level(make_level(ST_OK, '0, '0, 1'b1));
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            book_count  = 0;
            ask_order   = 1'b0;
            o_errors    = 0;
            o_in_beats  = 0;
            o_out_beats = 0;
            expected_levels_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                ask_order = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                o_in_beats++;
                book_update(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                o_out_beats++;
                if (expected_levels_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result beat, expected none, actual %p",
                             $time, i_out_data);
                end else begin
                    want = expected_levels_q.pop_front();
                    if (i_out_data.status !== want.status) begin
                        o_errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_out_data.status);
                    end
                    if (i_out_data.level_price !== want.level_price) begin
                        o_errors++;
                        $display("%0t: level_price expected %0d actual %0d",
                                 $time, want.level_price, i_out_data.level_price);
                    end
                    if (i_out_data.level_size !== want.level_size) begin
                        o_errors++;
                        $display("%0t: level_size expected %0d actual %0d",
                                 $time, want.level_size, i_out_data.level_size);
                    end
                    if (i_out_data.last !== want.last) begin
                        o_errors++;
                        $display("%0t: last expected %0d actual %0d",
                                 $time, want.last, i_out_data.last);
                    end
                end
            end
        end
        o_pending = expected_levels_q.size();
    end

endmodule

// ----- dv/sorted_price_level_book_top_tb.sv -----
// ----------------------------------------------------------------------------
// Sorted price level book testbench
// Drives directed and random add, remove, read and idle commands on both
// sort orders, with random idling on both sides, a long output hold-off and
// a drain pause, and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module sorted_price_level_book_top_tb;
    import splb_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 250;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_stall;
    t_in   i_in_data;
    logic  o_out_valid;
    logic  i_out_stall;
    t_out  o_out_data;
    logic  i_cfg_valid;
    logic  o_cfg_ready;
    logic  i_cfg_data;

    int    errors;
    int    pending;
    int    in_beats;
    int    out_beats;
    bit    idle_on;
    bit    hold_req;
    int    quiet_cycles;
    logic signed [47:0] price_pool [40];

    sorted_price_level_book_top #(.DEPTH(32)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    sorted_price_level_book_checker book_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_in_beats  (in_beats),
        .o_out_beats (out_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles.", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int n;
        bit hold_seen;
        i_out_stall = 1'b0;
        hold_seen   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_seen) begin
                hold_seen = 1'b1;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 17);
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_beat(t_in it);
        int n;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 17);
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_cmd(logic [1:0] f, logic signed [47:0] p, logic [31:0] q,
                            logic [5:0] rc);
        t_in it;
        it.func       = f;
        it.price      = p;
        it.quantity   = q;
        it.read_count = rc;
        send_beat(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic set_side(logic ask);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= ask;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_beats(int count);
        int          r;
        logic [1:0]  f;
        logic [31:0] q;
        logic signed [47:0] p;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            f = (r < 45) ? FUNC_ADD : (r < 78) ? FUNC_REMOVE : (r < 94) ? FUNC_READ : FUNC_NOP;
            p = ($urandom_range(0, 9) == 0) ? 48'({$urandom, $urandom}) :
                price_pool[$urandom_range(0, 39)];
            r = $urandom_range(0, 9);
            q = (r == 0) ? $urandom : (r == 1) ? 32'd0 : $urandom_range(1, 8);
            send_cmd(f, p, q, 6'($urandom_range(0, 63)));
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 1'b0;
        idle_on     = 1'b1;
        hold_req    = 1'b0;
        foreach (price_pool[i])
            price_pool[i] = 48'({$urandom, $urandom});
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_side(1'b1);
        send_cmd(FUNC_READ, '0, '0, 6'd0);
        send_cmd(FUNC_READ, '0, '0, 6'd1);
        send_cmd(FUNC_ADD, 48'sh800000000000, 32'hFFFFFFFF, '0);
        send_cmd(FUNC_ADD, 48'sh7FFFFFFFFFFF, 32'd5, '0);
        send_cmd(FUNC_ADD, 48'sd100, 32'd0, '0);
        send_cmd(FUNC_REMOVE, 48'sd100, 32'd0, '0);
        send_cmd(FUNC_REMOVE, 48'sd77, 32'd1, '0);
        send_cmd(FUNC_REMOVE, 48'sh7FFFFFFFFFFF, 32'd6, '0);
        send_cmd(FUNC_REMOVE, 48'sh7FFFFFFFFFFF, 32'd2, '0);
        send_cmd(FUNC_NOP, 48'sh555555555555, 32'hAAAAAAAA, 6'h2A);
        send_cmd(FUNC_READ, '0, '0, 6'd32);
        send_cmd(FUNC_READ, '0, '0, 6'd63);
        for (int i = 0; i < 33; i++)
            send_cmd(FUNC_ADD, price_pool[i], $urandom_range(1, 8), '0);
        send_cmd(FUNC_ADD, price_pool[0], 32'd1, '0);
        send_cmd(FUNC_READ, '0, '0, 6'd32);
        for (int i = 0; i < 20; i++)
            send_cmd(FUNC_ADD, price_pool[1], 32'hFFFFFFFF, '0);
        hold_req = 1'b1;
        random_beats(10);
        random_beats(40);

        set_side(1'b0);
        send_cmd(FUNC_READ, '0, '0, 6'd40);
        random_beats(40);
        drain();
        random_beats(10);

        set_side(1'b1);
        idle_on = 1'b0;
        random_beats(30);

        drain();
        repeat (40) @(posedge i_clk);
        $display("Covered %0d input beats and %0d result beats on ask and bid ordering,",
                 in_beats, out_beats);
        $display("including a full table, large sizes, rejected removes and padded reads.");
        if (errors == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
